@@ design/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the melody string tone player
// Holds the phase enum, queue entry and result layouts, register indexes,
// field widths, the note period table and the pause symbol decoder.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Field widths fixed by the stream format
    localparam int CHAR_W     = 8;
    localparam int UNIT_W     = 10;
    localparam int DUR_MS_W   = 14;
    localparam int PERIOD_W   = 12;
    localparam int HALF_W     = 11;
    localparam int PAUSE_MS_W = 5;
    localparam int DIGIT_W    = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 14;
    localparam int OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DURATION_UNIT    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_DURATION = 1'd1;

    // Reset values of the configuration registers
    localparam logic [UNIT_W-1:0]   UNIT_RESET        = 10'd200;
    localparam logic [DUR_MS_W-1:0] DEFAULT_DUR_RESET = 14'd400;

    // Item kinds carried in tuser
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Playback phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_REST,
        PH_PAUSE
    } msp_phase_t;

    // One classified item, as queued between front and back
    typedef struct packed {
        logic                  is_tick;
        logic                  is_zero;
        logic [PERIOD_W-1:0]   period_us;
        logic [DUR_MS_W-1:0]   dur_ms;
        logic [PAUSE_MS_W-1:0] pause_ms;
    } msp_entry_t;

    // One result item, pin level in the lowest bit
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic pin_level;
    } msp_result_t;

    // Tone period in microseconds for a note letter, zero for a rest
    function automatic logic [PERIOD_W-1:0] note_period(input logic [CHAR_W-1:0] ch);
        logic [PERIOD_W-1:0] p;
        unique case (ch)
            8'h41:   p = 12'd2272;  // A
            8'h42:   p = 12'd2024;  // B
            8'h43:   p = 12'd3816;  // C
            8'h44:   p = 12'd3401;  // D
            8'h45:   p = 12'd3030;  // E
            8'h46:   p = 12'd2865;  // F
            8'h47:   p = 12'd2551;  // G
            8'h61:   p = 12'd1136;  // a
            8'h62:   p = 12'd1012;  // b
            8'h63:   p = 12'd1912;  // c
            8'h64:   p = 12'd1703;  // d
            8'h65:   p = 12'd1517;  // e
            8'h66:   p = 12'd1432;  // f
            8'h67:   p = 12'd1275;  // g
            default: p = '0;
        endcase
        return p;
    endfunction

    // Pause length in milliseconds for a pause symbol
    function automatic logic [PAUSE_MS_W-1:0] pause_ms_of(input logic [CHAR_W-1:0] ch);
        logic [PAUSE_MS_W-1:0] ms;
        unique case (ch)
            8'h2B:   ms = 5'd0;   // plus
            8'h2C:   ms = 5'd5;   // comma
            8'h2E:   ms = 5'd20;  // period
            8'h5F:   ms = 5'd30;  // underscore
            default: ms = 5'd5;
        endcase
        return ms;
    endfunction

endpackage

@@ design/msp_front.sv @@
// ----------------------------------------------------------------------------
// msp_front: input side of the melody string tone player
// Holds the configuration registers, takes input transfers and classifies
// each character into note period, duration and pause fields for the queue.
// ----------------------------------------------------------------------------
module msp_front
    import msp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,
    input  logic                  s_tuser,
    input  logic                  push_ready,
    output logic                  push_valid,
    output msp_entry_t            push_entry
);

    logic [UNIT_W-1:0]   unit_reg;
    logic [DUR_MS_W-1:0] default_dur_reg;
    logic                is_digit;
    logic [DIGIT_W-1:0]  digit;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg        <= UNIT_RESET;
            default_dur_reg <= DEFAULT_DUR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DURATION_UNIT:    unit_reg        <= cfg_wdata[UNIT_W-1:0];
                REG_DEFAULT_DURATION: default_dur_reg <= cfg_wdata[DUR_MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pass the handshake through to the queue
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // Classify the character for every slot of a group
    assign is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    assign digit    = DIGIT_W'(s_tdata - 8'h30);

    always_comb begin
        push_entry.is_tick   = (s_tuser == CMD_TICK);
        push_entry.is_zero   = (s_tdata == '0);
        push_entry.period_us = note_period(s_tdata);
        push_entry.dur_ms    = is_digit ? DUR_MS_W'(digit * unit_reg) : default_dur_reg;
        push_entry.pause_ms  = pause_ms_of(s_tdata);
    end

endmodule

@@ design/msp_queue.sv @@
// ----------------------------------------------------------------------------
// msp_queue: short queue of classified items
// Decouples the input side from playback so each side can stall alone.
// ----------------------------------------------------------------------------
module msp_queue
    import msp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  msp_entry_t push_entry,
    output logic       head_valid,
    output msp_entry_t head_entry,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    msp_entry_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Occupancy never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

    // An empty queue has its two pointers equal
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

endmodule

@@ design/msp_back.sv @@
// ----------------------------------------------------------------------------
// msp_back: playback side of the melody string tone player
// Collects character groups, runs tone, rest and pause phases on tick items
// and registers one result per item behind an output stage.
// ----------------------------------------------------------------------------
module msp_back
    import msp_pkg::*;
#(
    parameter int TICKS_PER_MS = 1000
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  msp_entry_t            head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int TICK_W  = $clog2(TICKS_PER_MS + 1);
    localparam int DUR_TW  = DUR_MS_W + TICK_W;
    localparam int ELAP_W  = DUR_TW + 1;
    localparam int PAUSE_W = PAUSE_MS_W + TICK_W;

    msp_phase_t          phase_reg, phase_next;
    logic [1:0]          slot_reg, slot_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [DUR_TW-1:0]   dur_ticks_reg, dur_ticks_next;
    logic [ELAP_W-1:0]   elapsed_reg, elapsed_next;
    logic [HALF_W-1:0]   half_cnt_reg, half_cnt_next;
    logic [PAUSE_W-1:0]  pause_reg, pause_next;
    logic                pin_reg, pin_next;
    logic                rej;

    logic                out_valid_reg;
    msp_result_t         out_data_reg;
    msp_result_t         result;

    logic [HALF_W-1:0]   half;
    logic [HALF_W-1:0]   half_inc;
    logic [ELAP_W-1:0]   elap_tone;
    logic [ELAP_W-1:0]   elap_rest;
    logic [DUR_TW-1:0]   new_dur_ticks;
    logic [PAUSE_W-1:0]  new_pause;

    // Take the next item when the output stage is free or draining
    assign pop = head_valid && (!out_valid_reg || m_tready);

    assign half          = period_reg[PERIOD_W-1:1];
    assign half_inc      = half_cnt_reg + 1'b1;
    assign elap_tone     = elapsed_reg + ELAP_W'(period_reg);
    assign elap_rest     = elapsed_reg + 1'b1;
    assign new_dur_ticks = DUR_TW'(head_entry.dur_ms) * DUR_TW'(TICKS_PER_MS);
    assign new_pause     = PAUSE_W'(head_entry.pause_ms) * PAUSE_W'(TICKS_PER_MS);

    // Next state of playback and group collection
    always_comb begin
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        period_next    = period_reg;
        dur_ticks_next = dur_ticks_reg;
        elapsed_next   = elapsed_reg;
        half_cnt_next  = half_cnt_reg;
        pause_next     = pause_reg;
        pin_next       = pin_reg;
        rej            = 1'b0;

        if (head_entry.is_tick) begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_HIGH: begin
                    half_cnt_next = half_inc;
                    if (half_inc >= half) begin
                        half_cnt_next = '0;
                        pin_next      = 1'b0;
                        phase_next    = PH_LOW;
                    end
                end
                PH_LOW: begin
                    half_cnt_next = half_inc;
                    if (half_inc >= half) begin
                        half_cnt_next = '0;
                        elapsed_next  = elap_tone;
                        if (elap_tone < ELAP_W'(dur_ticks_reg)) begin
                            pin_next   = 1'b1;
                            phase_next = PH_HIGH;
                        end else begin
                            pin_next   = 1'b0;
                            phase_next = (pause_reg != '0) ? PH_PAUSE : PH_IDLE;
                        end
                    end
                end
                PH_REST: begin
                    elapsed_next = elap_rest;
                    if (elap_rest >= ELAP_W'(dur_ticks_reg)) begin
                        pin_next   = 1'b0;
                        phase_next = (pause_reg != '0) ? PH_PAUSE : PH_IDLE;
                    end
                end
                PH_PAUSE: begin
                    if (pause_reg != '0) begin
                        pause_next = pause_reg - 1'b1;
                    end
                    if (pause_reg <= PAUSE_W'(1)) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end else if (phase_reg != PH_IDLE) begin
            rej = 1'b1;
        end else if (head_entry.is_zero) begin
            slot_next = 2'd0;
        end else if (slot_reg == 2'd0) begin
            period_next = head_entry.period_us;
            slot_next   = 2'd1;
        end else if (slot_reg == 2'd1) begin
            dur_ticks_next = new_dur_ticks;
            slot_next      = 2'd2;
        end else begin
            // Third character: latch the pause and start the group
            pause_next    = new_pause;
            slot_next     = 2'd0;
            elapsed_next  = '0;
            half_cnt_next = '0;
            if (dur_ticks_reg == '0) begin
                pin_next   = 1'b0;
                phase_next = (new_pause != '0) ? PH_PAUSE : PH_IDLE;
            end else if (period_reg != '0) begin
                pin_next   = 1'b1;
                phase_next = PH_HIGH;
            end else begin
                pin_next   = 1'b0;
                phase_next = PH_REST;
            end
        end
    end

    // Result of the item, seen after its update
    always_comb begin
        result.pin_level = pin_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            slot_reg      <= 2'd0;
            period_reg    <= '0;
            dur_ticks_reg <= '0;
            elapsed_reg   <= '0;
            half_cnt_reg  <= '0;
            pause_reg     <= '0;
            pin_reg       <= 1'b0;
        end else if (pop) begin
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            period_reg    <= period_next;
            dur_ticks_reg <= dur_ticks_next;
            elapsed_reg   <= elapsed_next;
            half_cnt_reg  <= half_cnt_next;
            pause_reg     <= pause_next;
            pin_reg       <= pin_next;
        end
    end

    // Hold the output stage until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

    // Pin is high exactly in the high half of a tone
    assert property (@(posedge aclk) disable iff (!aresetn)
        pin_reg == (phase_reg == PH_HIGH))
        else $error("pin level disagrees with phase");

    // A tone always has a nonzero period
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> (period_reg != '0))
        else $error("tone phase with zero period");

    // Half period counter stays below its limit during a tone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> (half_cnt_reg < half))
        else $error("half period counter overran");

    // A pause phase always has time left
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAUSE) |-> (pause_reg != '0))
        else $error("pause phase with nothing left");

endmodule

@@ design/melody_string_tone_player_top.sv @@
// ----------------------------------------------------------------------------
// melody_string_tone_player_top: buzzer melody sequencer
// Takes song characters in groups of three (note, duration, pause) and plays
// them on one-microsecond tick transfers, one result transfer per input.
//
//   channel  direction  payload
//   s_       in         tdata[7:0] song_char, tuser[0] cmd (0 char, 1 tick)
//   m_       out        tdata[0] pin_level, [1] busy_res, [2] rejected
//   cfg_     in         index 0 duration_unit_ms, index 1 default_duration_ms
//
// One transfer in and one out per cycle sustained while m_ does not stall; an
// input is written into the queue, then its playback update into the output register.
// Reset is synchronous on aresetn low; configuration is back to 200 / 400 ms.
// A stall on m_ holds the output register; the queue of QUEUE_DEPTH entries
// keeps taking input until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module melody_string_tone_player_top
    import msp_pkg::*;
#(
    parameter int TICKS_PER_MS = 1000,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] song_char
    input  logic                  s_tuser,   // [0] cmd
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] pin_level, [1] busy_res, [2] rejected
);

    logic       push_valid;
    logic       push_ready;
    msp_entry_t push_entry;
    logic       head_valid;
    msp_entry_t head_entry;
    logic       pop;

    msp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    msp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    msp_back #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
